[hdl/assert_macros.svh]
// Assertion macros shared by the timer queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock edge outside reset.
`define DLTS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("timer queue check failed");

// Implication checked on every clock edge outside reset.
`define DLTS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer queue check failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define DLTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer queue check failed");

`endif

[hdl/dlts_pkg.sv]
// Package: constants, codes and slot entry type of the delta-list timer queue.
package dlts_pkg;

  localparam int MAX_TASKS = 32;
  localparam int ADDR_W    = $clog2(MAX_TASKS);
  localparam int LINK_W    = 6;
  localparam int DELTA_W   = 16;
  localparam int TAG_W     = 8;

  localparam logic [LINK_W-1:0] LINK_END = '1;
  localparam logic [LINK_W-1:0] MAX_L    = LINK_W'(MAX_TASKS);

  // Request kinds
  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_DISPATCH = 3'd1;
  localparam logic [2:0] KIND_ADD      = 3'd2;
  localparam logic [2:0] KIND_DELETE   = 3'd3;
  localparam logic [2:0] KIND_CLEAR    = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [DELTA_W-1:0] period;
    logic               ready;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic is_slot(input logic [LINK_W-1:0] x);
    return x < MAX_L;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LINK_W-1:0] x);
    return x[ADDR_W-1:0];
  endfunction

endpackage

[hdl/dlts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dlts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word; hold it while no read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/delta_list_timer_scheduler.sv]
// Top level: sequencer of the delta-list timer queue over its link and entry RAMs.
//
// One request is taken when start is high and busy is low; its single result
// appears on status, fired, result_slot and result_tag for exactly one cycle
// with done high and must be captured then. Requests are handled one at a
// time. A tick, dispatch or delete on an empty list, a refused add or an
// unknown kind is answered from idle without a RAM read; a tick or a one-shot
// dispatch acts on the head entry alone. An add or a periodic dispatch walks
// the list entry by entry and stops before the first entry with a larger
// delta or at the end of the list, then links in the new entry. A delete
// searches entry by entry for the slot; when it is found, its delta is added
// to its successor, if any, and it is unlinked and freed. Every list step
// costs one read of the link and entry RAMs, whose read data is registered.
// After reset and on a clear request a sweep over all MAX_TASKS slots rebuilds
// the free chain; busy stays high during it, a clear answers as the sweep
// ends, and reset gives no result.
module delta_list_timer_scheduler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    kind,
  input  logic [dlts_pkg::DELTA_W-1:0]  delay_ticks,
  input  logic [dlts_pkg::DELTA_W-1:0]  period_ticks,
  input  logic [4:0]                    slot_id,
  input  logic [dlts_pkg::TAG_W-1:0]    handler_tag,
  output logic                          done,
  output logic [1:0]                    status,
  output logic                          fired,
  output logic [4:0]                    result_slot,
  output logic [dlts_pkg::TAG_W-1:0]    result_tag
);
  import dlts_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [15:0] {
    ST_IDLE  = 16'h0001,
    ST_CLR   = 16'h0002,
    ST_TICK  = 16'h0004,
    ST_DISP  = 16'h0008,
    ST_ADD   = 16'h0010,
    ST_WRD   = 16'h0020,
    ST_WCHK  = 16'h0040,
    ST_FIN1  = 16'h0080,
    ST_FIN2  = 16'h0100,
    ST_DCHK  = 16'h0200,
    ST_DNRD  = 16'h0400,
    ST_DSUM  = 16'h0800,
    ST_DUNL1 = 16'h1000,
    ST_DUNL2 = 16'h2000
  } state_t;

  state_t              state;
  logic [LINK_W-1:0]   active_head, free_head;
  logic [LINK_W-1:0]   cur, prev, sslot, nx, sid;
  logic [LINK_W-1:0]   cnt;
  logic                tail, clr_reply;
  entry_t              sw;
  logic [DELTA_W-1:0]  dcur;

  // RAM ports
  logic                lwe, dwe, re;
  logic [ADDR_W-1:0]   lwaddr, dwaddr, raddr;
  logic [LINK_W-1:0]   lwdata, link_rd;
  entry_t              dwdata, ent_rd;
  logic [ENTRY_W-1:0]  ent_raw;

  dlts_ram #(.WIDTH(LINK_W), .DEPTH(MAX_TASKS)) u_link_ram (
    .clk(clk), .we(lwe), .waddr(lwaddr), .wdata(lwdata),
    .re(re), .raddr(raddr), .rdata(link_rd)
  );

  dlts_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TASKS)) u_entry_ram (
    .clk(clk), .we(dwe), .waddr(dwaddr), .wdata(dwdata),
    .re(re), .raddr(raddr), .rdata(ent_raw)
  );

  assign ent_rd = entry_t'(ent_raw);
  assign busy   = (state != ST_IDLE);

  logic               accept;
  logic [DELTA_W-1:0] tick_delta, ins_diff;
  logic [DELTA_W:0]   del_sum;
  logic [DELTA_W-1:0] del_sat;
  logic [LINK_W-1:0]  cnt_inc;

  assign accept     = start && !busy;
  assign tick_delta = (ent_rd.delta != '0) ? ent_rd.delta - 1'b1 : ent_rd.delta;
  assign ins_diff   = ent_rd.delta - sw.delta;
  assign del_sum    = {1'b0, ent_rd.delta} + {1'b0, dcur};
  assign del_sat    = del_sum[DELTA_W] ? '1 : del_sum[DELTA_W-1:0];
  assign cnt_inc    = cnt + 1'b1;

  // Drive RAM reads and writes for the current step
  always_comb begin
    lwe    = 1'b0;
    lwaddr = slot_addr(cur);
    lwdata = LINK_END;
    dwe    = 1'b0;
    dwaddr = slot_addr(cur);
    dwdata = '0;
    re     = 1'b0;
    raddr  = slot_addr(active_head);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (kind == KIND_ADD) begin
            re    = is_slot(free_head);
            raddr = slot_addr(free_head);
          end else if (kind == KIND_TICK || kind == KIND_DISPATCH ||
                       kind == KIND_DELETE) begin
            re = is_slot(active_head);
          end
        end
      end
      ST_CLR: begin
        lwe    = 1'b1;
        lwaddr = slot_addr(cnt);
        lwdata = (cnt == MAX_L - 1'b1) ? LINK_END : cnt_inc;
        dwe    = 1'b1;
        dwaddr = slot_addr(cnt);
      end
      ST_TICK: begin
        dwe          = 1'b1;
        dwdata       = ent_rd;
        dwdata.delta = tick_delta;
        dwdata.ready = ent_rd.ready || (tick_delta == '0);
      end
      ST_DISP: begin
        if (ent_rd.ready && ent_rd.period == '0) begin
          lwe    = 1'b1;
          lwdata = free_head;
          dwe    = 1'b1;
        end
      end
      ST_WRD: begin
        re    = is_slot(cur) && (cnt < MAX_L);
        raddr = slot_addr(cur);
      end
      ST_FIN1: begin
        lwe    = 1'b1;
        lwaddr = slot_addr(sslot);
        lwdata = tail ? LINK_END : cur;
        dwe    = !tail;
        dwdata = ent_rd;
        dwdata.delta = ins_diff;
        dwdata.ready = ent_rd.ready || (ins_diff == '0);
      end
      ST_FIN2: begin
        lwe    = is_slot(prev);
        lwaddr = slot_addr(prev);
        lwdata = sslot;
        dwe    = 1'b1;
        dwaddr = slot_addr(sslot);
        dwdata = sw;
        dwdata.ready = sw.ready || (sw.delta == '0);
      end
      ST_DCHK: begin
        if (cur != sid) begin
          re    = is_slot(link_rd) && (cnt_inc < MAX_L);
          raddr = slot_addr(link_rd);
        end
      end
      ST_DNRD: begin
        re    = 1'b1;
        raddr = slot_addr(nx);
      end
      ST_DSUM: begin
        dwe          = 1'b1;
        dwaddr       = slot_addr(nx);
        dwdata       = ent_rd;
        dwdata.delta = del_sat;
        dwdata.ready = (del_sat != '0) ? 1'b0 : ent_rd.ready;
      end
      ST_DUNL1: begin
        lwe    = is_slot(prev);
        lwaddr = slot_addr(prev);
        lwdata = nx;
        dwe    = 1'b1;
      end
      ST_DUNL2: begin
        lwe    = 1'b1;
        lwdata = free_head;
      end
      default: begin
        lwe = 1'b0;
      end
    endcase
  end

  // Sequence each request through its read, modify and write-back steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLR;
      cnt         <= '0;
      clr_reply   <= 1'b0;
      done        <= 1'b0;
      active_head <= LINK_END;
      free_head   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            status      <= STAT_OK;
            fired       <= 1'b0;
            result_slot <= '0;
            result_tag  <= '0;
            cur         <= active_head;
            prev        <= LINK_END;
            cnt         <= '0;
            sid         <= {1'b0, slot_id};
            case (kind)
              KIND_TICK: begin
                if (is_slot(active_head)) state <= ST_TICK;
                else done <= 1'b1;
              end
              KIND_DISPATCH: begin
                if (is_slot(active_head)) state <= ST_DISP;
                else done <= 1'b1;
              end
              KIND_ADD: begin
                if (is_slot(free_head)) begin
                  sslot       <= free_head;
                  sw          <= '{delta: delay_ticks, period: period_ticks,
                                   ready: 1'b0, tag: handler_tag};
                  result_slot <= free_head[4:0];
                  state       <= ST_ADD;
                end else begin
                  status <= STAT_FULL;
                  done   <= 1'b1;
                end
              end
              KIND_DELETE: begin
                if (is_slot(active_head)) state <= ST_DCHK;
                else begin
                  status <= STAT_EMPTY;
                  done   <= 1'b1;
                end
              end
              KIND_CLEAR: begin
                clr_reply <= 1'b1;
                state     <= ST_CLR;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        ST_CLR: begin
          cnt <= cnt_inc;
          if (cnt == MAX_L - 1'b1) begin
            active_head <= LINK_END;
            free_head   <= '0;
            done        <= clr_reply;
            clr_reply   <= 1'b0;
            state       <= ST_IDLE;
          end
        end
        ST_TICK: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        ST_DISP: begin
          if (!ent_rd.ready) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            fired       <= 1'b1;
            result_slot <= active_head[4:0];
            result_tag  <= ent_rd.tag;
            active_head <= link_rd;
            if (ent_rd.period == '0) begin
              free_head <= active_head;
              done      <= 1'b1;
              state     <= ST_IDLE;
            end else begin
              sslot <= active_head;
              sw    <= '{delta: ent_rd.period, period: ent_rd.period,
                         ready: 1'b0, tag: ent_rd.tag};
              cur   <= link_rd;
              state <= ST_WRD;
            end
          end
        end
        ST_ADD: begin
          free_head <= link_rd;
          state     <= ST_WRD;
        end
        ST_WRD: begin
          if (is_slot(cur) && (cnt < MAX_L)) begin
            state <= ST_WCHK;
          end else begin
            tail  <= 1'b1;
            state <= ST_FIN1;
          end
        end
        ST_WCHK: begin
          if (ent_rd.delta > sw.delta) begin
            tail  <= 1'b0;
            state <= ST_FIN1;
          end else begin
            sw.delta <= sw.delta - ent_rd.delta;
            prev     <= cur;
            cur      <= link_rd;
            cnt      <= cnt_inc;
            state    <= ST_WRD;
          end
        end
        ST_FIN1: state <= ST_FIN2;
        ST_FIN2: begin
          if (!is_slot(prev)) active_head <= sslot;
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        ST_DCHK: begin
          if (cur == sid) begin
            nx    <= link_rd;
            dcur  <= ent_rd.delta;
            state <= is_slot(link_rd) ? ST_DNRD : ST_DUNL1;
          end else begin
            prev <= cur;
            cur  <= link_rd;
            cnt  <= cnt_inc;
            if (!(is_slot(link_rd) && (cnt_inc < MAX_L))) begin
              done  <= 1'b1;
              state <= ST_IDLE;
            end
          end
        end
        ST_DNRD: state <= ST_DSUM;
        ST_DSUM: state <= ST_DUNL1;
        ST_DUNL1: begin
          if (!is_slot(prev)) active_head <= nx;
          state <= ST_DUNL2;
        end
        ST_DUNL2: begin
          free_head <= cur;
          done      <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A result transfer only ever ends a request
  `DLTS_ASSERT_IMPLY(a_done_idle, done, !busy)
  // In the cycle after an accepted request the sequencer is busy or gives the result
  `DLTS_ASSERT_NEXT(a_accept_busy, accept, busy || done)
  // A fired task always reports ok
  `DLTS_ASSERT_IMPLY(a_fired_ok, done && fired, status == STAT_OK)
  // The active and free lists never share a head slot
  `DLTS_ASSERT_ALWAYS(a_heads_apart,
    (active_head != free_head) || (active_head == LINK_END))

endmodule
